// ===== src/sqlt_pkg.sv =====
// Package for the SQL query tokenizer: beat types, token codes, scan modes.
// No dependencies.
`timescale 1ns / 1ps

package sqlt_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_marker;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  token_class;
        logic [4:0]  token_detail;
        logic [15:0] start_position;
        logic [15:0] token_length;
        logic [2:0]  error_code;
        logic        last_of_run;
    } out_beat_t;

    typedef enum logic [7:0] {
        M_IDLE  = 8'b0000_0001,
        M_WORD  = 8'b0000_0010,
        M_NUM   = 8'b0000_0100,
        M_PEND  = 8'b0000_1000,
        M_BIN   = 8'b0001_0000,
        M_HEX   = 8'b0010_0000,
        M_QUOTE = 8'b0100_0000,
        M_JSON  = 8'b1000_0000
    } mode_t;

    localparam logic [2:0] C_KEYWORD = 3'd0;
    localparam logic [2:0] C_IDENT   = 3'd1;
    localparam logic [2:0] C_LITERAL = 3'd2;
    localparam logic [2:0] C_OPER    = 3'd3;
    localparam logic [2:0] C_SYMBOL  = 3'd4;
    localparam logic [2:0] C_EOF     = 3'd5;
    localparam logic [2:0] C_UNKNOWN = 3'd6;

    localparam logic [4:0] L_STRING   = 5'd0;
    localparam logic [4:0] L_CHAR     = 5'd1;
    localparam logic [4:0] L_INTEGER  = 5'd2;
    localparam logic [4:0] L_FLOAT    = 5'd3;
    localparam logic [4:0] L_BINARY   = 5'd4;
    localparam logic [4:0] L_HEX      = 5'd5;
    localparam logic [4:0] L_DATE     = 5'd6;
    localparam logic [4:0] L_TIME     = 5'd7;
    localparam logic [4:0] L_DATETIME = 5'd8;
    localparam logic [4:0] L_JSON     = 5'd9;
    localparam logic [4:0] L_BOOLEAN  = 5'd10;
    localparam logic [4:0] L_NULL     = 5'd11;

    localparam logic [4:0] OP_PLUS    = 5'd0;
    localparam logic [4:0] OP_MINUS   = 5'd1;
    localparam logic [4:0] OP_STAR    = 5'd2;
    localparam logic [4:0] OP_SLASH   = 5'd3;
    localparam logic [4:0] OP_PERCENT = 5'd4;
    localparam logic [4:0] OP_EQ      = 5'd5;
    localparam logic [4:0] OP_LT      = 5'd6;
    localparam logic [4:0] OP_GT      = 5'd7;
    localparam logic [4:0] OP_LE      = 5'd8;
    localparam logic [4:0] OP_GE      = 5'd9;
    localparam logic [4:0] OP_NE      = 5'd10;

    localparam logic [4:0] SYM_COMMA  = 5'd0;
    localparam logic [4:0] SYM_SEMI   = 5'd1;
    localparam logic [4:0] SYM_LPAREN = 5'd2;
    localparam logic [4:0] SYM_RPAREN = 5'd3;
    localparam logic [4:0] SYM_RBRACE = 5'd5;
    localparam logic [4:0] SYM_LBRACK = 5'd6;
    localparam logic [4:0] SYM_RBRACK = 5'd7;

    localparam logic [2:0] E_NONE  = 3'd0;
    localparam logic [2:0] E_QUOTE = 3'd1;
    localparam logic [2:0] E_BIN   = 3'd2;
    localparam logic [2:0] E_HEX   = 3'd3;
    localparam logic [2:0] E_JSON  = 3'd4;

    localparam int DATE_LEN     = 12;
    localparam int TIME_LEN     = 10;
    localparam int DATETIME_LEN = 21;

    localparam int NUM_KEYWORDS = 23;

    // Keywords packed right-aligned in 64 bits, with their lengths.
    function automatic logic [63:0] kw_chars(input int k);
        case (k)
            0:  kw_chars = 64'("SELECT");
            1:  kw_chars = 64'("FROM");
            2:  kw_chars = 64'("WHERE");
            3:  kw_chars = 64'("INSERT");
            4:  kw_chars = 64'("UPDATE");
            5:  kw_chars = 64'("DELETE");
            6:  kw_chars = 64'("CREATE");
            7:  kw_chars = 64'("DROP");
            8:  kw_chars = 64'("ALTER");
            9:  kw_chars = 64'("JOIN");
            10: kw_chars = 64'("ON");
            11: kw_chars = 64'("GROUP");
            12: kw_chars = 64'("BY");
            13: kw_chars = 64'("HAVING");
            14: kw_chars = 64'("ORDER");
            15: kw_chars = 64'("LIMIT");
            16: kw_chars = 64'("OFFSET");
            17: kw_chars = 64'("UNION");
            18: kw_chars = 64'("ALL");
            19: kw_chars = 64'("DISTINCT");
            20: kw_chars = 64'("AS");
            21: kw_chars = 64'("IN");
            22: kw_chars = 64'("IS");
            default: kw_chars = '0;
        endcase
    endfunction

    function automatic logic [3:0] kw_len(input int k);
        case (k)
            0, 3, 4, 5, 6, 13, 16:  kw_len = 4'd6;
            1, 7, 9:                kw_len = 4'd4;
            2, 8, 11, 14, 15, 17:   kw_len = 4'd5;
            10, 12, 20, 21, 22:     kw_len = 4'd2;
            18:                     kw_len = 4'd3;
            19:                     kw_len = 4'd8;
            default:                kw_len = 4'd0;
        endcase
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        to_upper = ((c >= "a") && (c <= "z")) ? c - 8'd32 : c;
    endfunction

endpackage

// ===== src/sqlt_word_class.sv =====
// Classifies a finished word: keyword, boolean or null literal, or identifier.
// Depends on sqlt_pkg.
`timescale 1ns / 1ps

module sqlt_word_class #(
    parameter int LEN_BITS = 16,
    parameter int KEYWORD_CHARS = 8
) (
    input  logic [63:0]         word_chars,
    input  logic [LEN_BITS-1:0] run_length,
    output logic [2:0]          token_class,
    output logic [4:0]          token_detail
);
    import sqlt_pkg::*;

    logic len_ok;
    logic [NUM_KEYWORDS-1:0] hit;

    assign len_ok = run_length <= LEN_BITS'(KEYWORD_CHARS);

    always_comb
    begin
        for (int k = 0; k < NUM_KEYWORDS; k++)
        begin
            hit[k] = (word_chars == kw_chars(k)) && (run_length == LEN_BITS'(kw_len(k)));
        end
    end

    always_comb
    begin
        token_class  = C_IDENT;
        token_detail = 5'd0;
        if (len_ok)
        begin
            if (((word_chars == 64'("TRUE")) && (run_length == LEN_BITS'(4)))
                || ((word_chars == 64'("FALSE")) && (run_length == LEN_BITS'(5))))
            begin
                token_class  = C_LITERAL;
                token_detail = L_BOOLEAN;
            end
            else if ((word_chars == 64'("NULL")) && (run_length == LEN_BITS'(4)))
            begin
                token_class  = C_LITERAL;
                token_detail = L_NULL;
            end
            else
            begin
                for (int k = NUM_KEYWORDS - 1; k >= 0; k--)
                begin
                    if (hit[k])
                    begin
                        token_class  = C_KEYWORD;
                        token_detail = 5'(k);
                    end
                end
            end
        end
    end

endmodule

// ===== src/sql_query_tokenizer.sv =====
// Top level of the SQL query tokenizer: byte scanner and four-entry result queue.
// Depends on sqlt_pkg and sqlt_word_class.
//
//  channel | dir | payload              | handshake
//  in      | in  | sqlt_pkg::in_beat_t  | in_valid / in_ready
//  out     | out | sqlt_pkg::out_beat_t | out_valid / out_ready
//
// One byte per cycle while in_ready is high: each accepted beat is scanned
// combinationally and its tokens, up to two, land in a four-entry result queue.
// A byte is taken while the queue has room for two more tokens, so the
// input stalls when the output side holds off or two-token beats outrun it.
// Reset returns the scanner to the start of a query; the end marker does too.
`timescale 1ns / 1ps

module sql_query_tokenizer #(
    parameter int POSITION_BITS = 16,
    parameter int DEPTH_BITS    = 8,
    parameter int KEYWORD_CHARS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sqlt_pkg::in_beat_t  in_data,
    input  logic                in_valid,
    output logic                in_ready,
    output sqlt_pkg::out_beat_t out_data,
    output logic                out_valid,
    input  logic                out_ready
);
    import sqlt_pkg::*;

    localparam int PB = POSITION_BITS;
    localparam logic [PB-1:0] POS_MAX = '1;
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

    mode_t                 mode_reg, mode_next;
    logic [PB-1:0]         start_reg, start_next;
    logic [PB-1:0]         pos_reg, pos_next;
    logic [PB-1:0]         len_reg, len_next;
    logic [63:0]           word_reg, word_next;
    logic                  qdouble_reg, qdouble_next;
    logic                  esc_reg, esc_next;
    logic [DEPTH_BITS-1:0] depth_reg, depth_next;
    logic                  jstr_reg, jstr_next;
    logic                  jdouble_reg, jdouble_next;
    logic                  dot_reg, dot_next;
    logic [7:0]            held_reg, held_next;
    logic [2:0]            fmt_reg, fmt_next;

    // Result queue
    out_beat_t  q_mem [4];
    logic [1:0] q_rd_reg, q_wr_reg;
    logic [2:0] q_cnt_reg;

    logic       accept, pop;
    logic [7:0] c;
    logic       endm;
    out_beat_t  t0, t1;
    logic       v0, v1;

    logic [2:0] wc_class;
    logic [4:0] wc_detail;

    sqlt_word_class #(
        .LEN_BITS      (PB),
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_word (
        .word_chars   (word_reg),
        .run_length   (len_reg),
        .token_class  (wc_class),
        .token_detail (wc_detail)
    );

    assign in_ready  = q_cnt_reg <= 3'd2;
    assign accept    = in_valid && in_ready;
    assign out_valid = q_cnt_reg != 3'd0;
    assign pop       = out_valid && out_ready;
    assign out_data  = q_mem[q_rd_reg];
    assign c         = in_data.char_code;
    assign endm      = in_data.end_marker;

    function automatic out_beat_t mk(input logic [2:0] cls, input logic [4:0] det,
                                     input logic [PB-1:0] st, input logic [PB-1:0] ln,
                                     input logic [2:0] err);
        out_beat_t r;
        r.token_class    = cls;
        r.token_detail   = det;
        r.start_position = (PB > 16 && (st >> 16) != '0) ? 16'hFFFF : 16'(st);
        r.token_length   = (PB > 16 && (ln >> 16) != '0) ? 16'hFFFF : 16'(ln);
        r.error_code     = err;
        r.last_of_run    = 1'b0;
        return r;
    endfunction

    function automatic logic pat_ok(input logic [PB-1:0] i, input logic [7:0] ch,
                                    input int which);
        logic d;
        logic hit;
        d   = is_digit(ch);
        hit = 1'b0;
        case (which)
            0:
            begin
                if (i < PB'(10))
                    hit = (i == PB'(4) || i == PB'(7)) ? (ch == "-") : d;
            end
            1:
            begin
                if (i < PB'(8))
                    hit = (i == PB'(2) || i == PB'(5)) ? (ch == ":") : d;
            end
            default:
            begin
                if (i < PB'(19))
                begin
                    if (i == PB'(4) || i == PB'(7))       hit = ch == "-";
                    else if (i == PB'(10))                hit = ch == " ";
                    else if (i == PB'(13) || i == PB'(16)) hit = ch == ":";
                    else                                   hit = d;
                end
            end
        endcase
        return hit;
    endfunction

    always_comb
    begin
        logic            redo;
        logic [PB-1:0]   grown;
        logic [PB-1:0]   ln2;
        logic [4:0]      det;
        logic [7:0]      qc;
        logic [PB-1:0]   i;
        logic [4:0]      pdet;

        mode_next    = mode_reg;
        start_next   = start_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        word_next    = word_reg;
        qdouble_next = qdouble_reg;
        esc_next     = esc_reg;
        depth_next   = depth_reg;
        jstr_next    = jstr_reg;
        jdouble_next = jdouble_reg;
        dot_next     = dot_reg;
        held_next    = held_reg;
        fmt_next     = fmt_reg;
        t0 = '0;
        t1 = '0;
        v0 = 1'b0;
        v1 = 1'b0;
        redo = 1'b0;
        grown = (len_reg != POS_MAX) ? len_reg + PB'(1) : len_reg;
        ln2 = '0;
        det = '0;
        qc = qdouble_reg ? 8'h22 : 8'h27;
        i = len_reg - PB'(1);
        pdet = (held_reg == "<") ? OP_LT : ((held_reg == ">") ? OP_GT : OP_MINUS);

        if (endm)
        begin
            v0 = 1'b1;
            case (mode_reg)
                M_WORD:  t0 = mk(wc_class, wc_detail, start_reg, len_reg, E_NONE);
                M_NUM:   t0 = mk(C_LITERAL, dot_reg ? L_FLOAT : L_INTEGER, start_reg,
                                 len_reg, E_NONE);
                M_PEND:  t0 = mk(C_OPER, pdet, start_reg, len_reg, E_NONE);
                M_QUOTE: t0 = mk(C_LITERAL, L_STRING, start_reg, len_reg, E_QUOTE);
                M_BIN:   t0 = mk(C_LITERAL, L_BINARY, start_reg, len_reg, E_BIN);
                M_HEX:   t0 = mk(C_LITERAL, L_HEX, start_reg, len_reg, E_HEX);
                M_JSON:  t0 = mk(C_LITERAL, L_JSON, start_reg, len_reg, E_JSON);
                default: v0 = 1'b0;
            endcase
            t1 = mk(C_EOF, 5'd0, pos_reg, '0, E_NONE);
            v1 = 1'b1;
            mode_next = M_IDLE;
            start_next = '0; pos_next = '0; len_next = '0; word_next = '0;
            qdouble_next = 1'b0; esc_next = 1'b0; depth_next = '0; jstr_next = 1'b0;
            jdouble_next = 1'b0; dot_next = 1'b0; held_next = '0; fmt_next = 3'b111;
        end
        else
        begin
            case (mode_reg)
                M_WORD:
                begin
                    if (len_reg == PB'(1) && c == 8'h27
                        && (word_reg[7:0] == "B" || word_reg[7:0] == "X"))
                    begin
                        mode_next = (word_reg[7:0] == "B") ? M_BIN : M_HEX;
                        len_next  = grown;
                    end
                    else if (is_alpha(c) || is_digit(c) || c == "_")
                    begin
                        len_next  = grown;
                        word_next = {word_reg[55:0], to_upper(c)};
                    end
                    else
                    begin
                        v0 = 1'b1;
                        t0 = mk(wc_class, wc_detail, start_reg, len_reg, E_NONE);
                        redo = 1'b1;
                    end
                end
                M_NUM:
                begin
                    if (is_digit(c))
                        len_next = grown;
                    else if (c == "." && !dot_reg)
                    begin
                        dot_next = 1'b1;
                        len_next = grown;
                    end
                    else
                    begin
                        v0 = 1'b1;
                        t0 = mk(C_LITERAL, dot_reg ? L_FLOAT : L_INTEGER, start_reg,
                                len_reg, E_NONE);
                        redo = 1'b1;
                    end
                end
                M_PEND:
                begin
                    if ((held_reg == "<" && (c == "=" || c == ">"))
                        || (held_reg == ">" && c == "="))
                    begin
                        len_next = grown;
                        v0 = 1'b1;
                        if (held_reg == ">")  det = OP_GE;
                        else if (c == "=")    det = OP_LE;
                        else                  det = OP_NE;
                        t0 = mk(C_OPER, det, start_reg, grown, E_NONE);
                        mode_next = M_IDLE;
                    end
                    else if (held_reg == "-" && is_digit(c))
                    begin
                        len_next  = grown;
                        mode_next = M_NUM;
                        dot_next  = 1'b0;
                    end
                    else
                    begin
                        v0 = 1'b1;
                        t0 = mk(C_OPER, pdet, start_reg, len_reg, E_NONE);
                        redo = 1'b1;
                    end
                end
                M_BIN, M_HEX:
                begin
                    len_next = grown;
                    if (c == 8'h27)
                    begin
                        v0 = 1'b1;
                        t0 = mk(C_LITERAL, (mode_reg == M_BIN) ? L_BINARY : L_HEX,
                                start_reg, grown, E_NONE);
                        mode_next = M_IDLE;
                    end
                end
                M_QUOTE:
                begin
                    len_next = grown;
                    if (!esc_reg && c == qc)
                    begin
                        ln2 = grown;
                        if (qdouble_reg)                                    det = L_STRING;
                        else if (fmt_reg[0] && ln2 == PB'(DATE_LEN))        det = L_DATE;
                        else if (fmt_reg[1] && ln2 == PB'(TIME_LEN))        det = L_TIME;
                        else if (fmt_reg[2] && ln2 == PB'(DATETIME_LEN))    det = L_DATETIME;
                        else det = (ln2 == PB'(3)) ? L_CHAR : L_STRING;
                        v0 = 1'b1;
                        t0 = mk(C_LITERAL, det, start_reg, ln2, E_NONE);
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        if (esc_reg)        esc_next = 1'b0;
                        else if (c == "\\") esc_next = 1'b1;
                        if (!pat_ok(i, c, 0)) fmt_next[0] = 1'b0;
                        if (!pat_ok(i, c, 1)) fmt_next[1] = 1'b0;
                        if (!pat_ok(i, c, 2)) fmt_next[2] = 1'b0;
                    end
                end
                M_JSON:
                begin
                    len_next = grown;
                    if (jstr_reg)
                    begin
                        if (esc_reg)        esc_next = 1'b0;
                        else if (c == "\\") esc_next = 1'b1;
                        else if (c == (jdouble_reg ? 8'h22 : 8'h27)) jstr_next = 1'b0;
                    end
                    else if (c == 8'h22 || c == 8'h27)
                    begin
                        jstr_next    = 1'b1;
                        jdouble_next = c == 8'h22;
                    end
                    else if (c == "{")
                    begin
                        if (depth_reg != DEPTH_MAX) depth_next = depth_reg + DEPTH_BITS'(1);
                    end
                    else if (c == "}")
                    begin
                        if (depth_reg <= DEPTH_BITS'(1))
                        begin
                            depth_next = '0;
                            v0 = 1'b1;
                            t0 = mk(C_LITERAL, L_JSON, start_reg, grown, E_NONE);
                            mode_next = M_IDLE;
                        end
                        else
                            depth_next = depth_reg - DEPTH_BITS'(1);
                    end
                end
                default: redo = 1'b1;
            endcase

            if (redo)
            begin
                start_next = pos_reg;
                len_next   = PB'(1);
                mode_next  = M_IDLE;
                if (is_space(c))
                begin
                end
                else if (is_digit(c))
                begin
                    mode_next = M_NUM;
                    dot_next  = 1'b0;
                end
                else if (c == "-" || c == "<" || c == ">")
                begin
                    mode_next = M_PEND;
                    held_next = c;
                end
                else if (c == 8'h22 || c == 8'h27)
                begin
                    mode_next    = M_QUOTE;
                    qdouble_next = c == 8'h22;
                    esc_next     = 1'b0;
                    fmt_next     = 3'b111;
                end
                else if (c == "{")
                begin
                    mode_next  = M_JSON;
                    depth_next = DEPTH_BITS'(1);
                    jstr_next  = 1'b0;
                    esc_next   = 1'b0;
                end
                else if (is_alpha(c))
                begin
                    mode_next = M_WORD;
                    word_next = {56'd0, to_upper(c)};
                end
                else
                begin
                    v1 = 1'b1;
                    case (c)
                        "+": t1 = mk(C_OPER, OP_PLUS, pos_reg, PB'(1), E_NONE);
                        "*": t1 = mk(C_OPER, OP_STAR, pos_reg, PB'(1), E_NONE);
                        "/": t1 = mk(C_OPER, OP_SLASH, pos_reg, PB'(1), E_NONE);
                        "%": t1 = mk(C_OPER, OP_PERCENT, pos_reg, PB'(1), E_NONE);
                        "=": t1 = mk(C_OPER, OP_EQ, pos_reg, PB'(1), E_NONE);
                        ",": t1 = mk(C_SYMBOL, SYM_COMMA, pos_reg, PB'(1), E_NONE);
                        ";": t1 = mk(C_SYMBOL, SYM_SEMI, pos_reg, PB'(1), E_NONE);
                        "(": t1 = mk(C_SYMBOL, SYM_LPAREN, pos_reg, PB'(1), E_NONE);
                        ")": t1 = mk(C_SYMBOL, SYM_RPAREN, pos_reg, PB'(1), E_NONE);
                        "}": t1 = mk(C_SYMBOL, SYM_RBRACE, pos_reg, PB'(1), E_NONE);
                        "[": t1 = mk(C_SYMBOL, SYM_LBRACK, pos_reg, PB'(1), E_NONE);
                        "]": t1 = mk(C_SYMBOL, SYM_RBRACK, pos_reg, PB'(1), E_NONE);
                        default: t1 = mk(C_UNKNOWN, 5'd0, pos_reg, PB'(1), E_NONE);
                    endcase
                end
            end
            if (pos_reg != POS_MAX) pos_next = pos_reg + PB'(1);
        end

        // Tag the final token of this beat.
        if (v1)      t1.last_of_run = 1'b1;
        else if (v0) t0.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= M_IDLE;
            start_reg   <= '0;
            pos_reg     <= '0;
            len_reg     <= '0;
            word_reg    <= '0;
            qdouble_reg <= 1'b0;
            esc_reg     <= 1'b0;
            depth_reg   <= '0;
            jstr_reg    <= 1'b0;
            jdouble_reg <= 1'b0;
            dot_reg     <= 1'b0;
            held_reg    <= '0;
            fmt_reg     <= 3'b111;
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            start_reg   <= start_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            word_reg    <= word_next;
            qdouble_reg <= qdouble_next;
            esc_reg     <= esc_next;
            depth_reg   <= depth_next;
            jstr_reg    <= jstr_next;
            jdouble_reg <= jdouble_next;
            dot_reg     <= dot_next;
            held_reg    <= held_next;
            fmt_reg     <= fmt_next;
        end
    end

    logic       push0, push1;
    logic [1:0] n_push;
    assign push0  = accept && v0;
    assign push1  = accept && v1;
    assign n_push = 2'(push0) + 2'(push1);

    always_ff @(posedge clk)
    begin
        if (push0)
            q_mem[q_wr_reg] <= t0;
        if (push1)
            q_mem[push0 ? q_wr_reg + 2'd1 : q_wr_reg] <= t1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_rd_reg  <= '0;
            q_wr_reg  <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            q_wr_reg  <= q_wr_reg + n_push;
            q_rd_reg  <= q_rd_reg + 2'(pop);
            q_cnt_reg <= q_cnt_reg + 3'(n_push) - 3'(pop);
        end
    end

endmodule

// ===== src/sqlt_checker.sv =====
// Port-level checker for the SQL query tokenizer, bound to the top level.
// Depends on sqlt_pkg.
`timescale 1ns / 1ps

module sqlt_checker (
    input logic                clk,
    input logic                rst_n,
    input sqlt_pkg::in_beat_t  in_data,
    input logic                in_valid,
    input logic                in_ready,
    input sqlt_pkg::out_beat_t out_data,
    input logic                out_valid,
    input logic                out_ready
);
    import sqlt_pkg::*;

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // End of input carries no length and is the last token of its beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.token_class == C_EOF |-> out_data.token_length == 16'd0
            && out_data.last_of_run)
        else $error("bad EOF token");

    // Error codes appear only on literals.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error_code != E_NONE |-> out_data.token_class == C_LITERAL)
        else $error("error code on non-literal");

    // Single-byte unknown tokens.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.token_class == C_UNKNOWN |-> out_data.token_length == 16'd1)
        else $error("unknown token length");

endmodule

bind sql_query_tokenizer sqlt_checker u_sqlt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
);
